FILE: sv/psar_pkg.sv
package psar_pkg;

    localparam int unsigned TIMER_W  = 16;
    localparam int unsigned LEN_W    = 14;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned RETRY_W  = 4;
    localparam int unsigned EVENT_W  = 4;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [TIMER_W-1:0] TIMER_MAX = 16'hFFFF;
    localparam int unsigned ACK_TYPE_POS = 4;
    localparam int unsigned ACK_MIN_LEN  = 5;

    localparam logic [TIMER_W-1:0] SEND_PERIOD_RST = 16'd100;
    localparam logic [TIMER_W-1:0] ACK_WAIT_RST    = 16'd10;
    localparam logic [BYTE_W-1:0]  ACK_CODE_RST    = 8'd0;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd3;

    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_RX_BYTE  = 2'd1,
        REQ_GAP      = 2'd2,
        REQ_TX_READY = 2'd3
    } t_req;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE    = 4'd0,
        EV_SEND    = 4'd1,
        EV_RESEND  = 4'd2,
        EV_ACK     = 4'd3,
        EV_GIVEUP  = 4'd4,
        EV_STORED  = 4'd5,
        EV_DROPPED = 4'd6,
        EV_TXBYTE  = 4'd7,
        EV_TXDONE  = 4'd8
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEND_PERIOD = 2'd0,
        CFG_ACK_WAIT    = 2'd1,
        CFG_ACK_CODE    = 2'd2,
        CFG_RETRY_LIMIT = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [TIMER_W-1:0] send_period;
        logic [TIMER_W-1:0] ack_wait_ticks;
        logic [BYTE_W-1:0]  ack_type_code;
        logic [RETRY_W-1:0] retry_limit;
    } t_cfg;

    // The reply check looks only at the fill count and the type byte, so of the frame's bytes that byte alone is kept.
    typedef struct packed {
        logic [TIMER_W-1:0] period_timer;
        logic               awaiting_reply;
        logic [TIMER_W-1:0] reply_timer;
        logic [RETRY_W-1:0] resend_count;
        logic [LEN_W-1:0]   saved_length;
        logic               rx_closed;
        logic [BYTE_W-1:0]  type_byte;
        logic [LEN_W-1:0]   tx_position;
        logic [LEN_W-1:0]   tx_total;
        logic               tx_running;
    } t_state;

    typedef struct packed {
        t_event           ev;
        logic [LEN_W-1:0] tx_index;
    } t_result;

endpackage

FILE: sv/psar_step.sv
module psar_step #(
    parameter int unsigned RX_SIZE = 256
) (
    input  psar_pkg::t_cfg                     i_cfg,
    input  psar_pkg::t_state                   i_state,
    input  logic [$clog2(RX_SIZE+1)-1:0]       i_fill,
    input  logic [1:0]                         i_req_type,
    input  logic [7:0]                         i_rx_byte,
    input  logic [13:0]                        i_frame_length,
    output psar_pkg::t_state                   o_state,
    output logic [$clog2(RX_SIZE+1)-1:0]       o_fill,
    output psar_pkg::t_result                  o_result
);
    import psar_pkg::*;

    localparam int unsigned FILL_W = $clog2(RX_SIZE + 1);

    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
        return (v == TIMER_MAX) ? v : v + 1'b1;
    endfunction

    t_state            n_state;
    logic [FILL_W-1:0] n_fill;
    t_result           n_result;

    always_comb begin
        n_state  = i_state;
        n_fill   = i_fill;
        n_result = '{ev: EV_NONE, tx_index: '0};
        unique case (t_req'(i_req_type))
            REQ_TICK: begin
                n_state.period_timer = sat_inc(i_state.period_timer);
                if (n_state.period_timer >= i_cfg.send_period && !i_state.awaiting_reply) begin
                    n_state.period_timer   = '0;
                    n_fill                 = '0;
                    n_state.rx_closed      = 1'b0;
                    n_state.saved_length   = i_frame_length;
                    n_state.tx_total       = i_frame_length;
                    n_state.tx_position    = '0;
                    n_state.tx_running     = (i_frame_length != '0);
                    n_state.awaiting_reply = 1'b1;
                    n_result.ev            = EV_SEND;
                end
                if (n_state.awaiting_reply) begin
                    n_state.reply_timer = sat_inc(i_state.reply_timer);
                    if (n_state.reply_timer >= i_cfg.ack_wait_ticks) begin
                        n_state.reply_timer = '0;
                        if (n_state.rx_closed) begin
                            if (n_fill >= FILL_W'(ACK_MIN_LEN)
                                && n_state.type_byte == i_cfg.ack_type_code) begin
                                n_state.resend_count   = '0;
                                n_state.awaiting_reply = 1'b0;
                                n_result.ev            = EV_ACK;
                            end else begin
                                // discard the reply and keep waiting
                                n_fill            = '0;
                                n_state.rx_closed = 1'b0;
                            end
                        end else begin
                            n_state.tx_total     = n_state.saved_length;
                            n_state.tx_position  = '0;
                            n_state.tx_running   = (n_state.saved_length != '0);
                            n_state.resend_count = i_state.resend_count + 1'b1;
                            if (n_state.resend_count >= i_cfg.retry_limit) begin
                                n_state.resend_count   = '0;
                                n_state.awaiting_reply = 1'b0;
                                n_result.ev            = EV_GIVEUP;
                            end else begin
                                n_result.ev = EV_RESEND;
                            end
                        end
                    end
                end
            end
            REQ_RX_BYTE: begin
                if (!i_state.rx_closed && i_fill < FILL_W'(RX_SIZE)) begin
                    if (i_fill == FILL_W'(ACK_TYPE_POS)) begin
                        n_state.type_byte = i_rx_byte;
                    end
                    n_fill      = i_fill + 1'b1;
                    n_result.ev = EV_STORED;
                end else begin
                    n_state.rx_closed = 1'b1;
                    n_result.ev       = EV_DROPPED;
                end
            end
            REQ_GAP: begin
                if (i_fill != '0) begin
                    n_state.rx_closed = 1'b1;
                end
            end
            REQ_TX_READY: begin
                if (i_state.tx_running) begin
                    n_result.tx_index   = i_state.tx_position;
                    n_state.tx_position = i_state.tx_position + 1'b1;
                    if (n_state.tx_position == i_state.tx_total) begin
                        n_state.tx_running = 1'b0;
                        n_result.ev        = EV_TXDONE;
                    end else begin
                        n_result.ev = EV_TXBYTE;
                    end
                end
            end
        endcase
    end

    assign o_state  = n_state;
    assign o_fill   = n_fill;
    assign o_result = n_result;

endmodule

FILE: sv/periodic_send_ack_retry_unit.sv
// Stop-and-wait sender with periodic send, reply check and retry. One word is
// taken every clock cycle unless o_in_stall is high, and its result is offered
// this way: the word is captured in an input register, one pass of next-state
// logic runs against the held protocol state, and the outcome lands in the
// result register, where a stalled consumer holds it and stalls the input side.
// Configuration writes take effect at the next edge and should be made while
// no word is in flight. Of the receive frame only the fill count and the type
// byte at position four are kept, as nothing else of the frame is ever used.
module periodic_send_ack_retry_unit #(
    parameter int unsigned RX_SIZE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_rx_byte,
    input  logic [13:0] i_frame_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_event_res,
    output logic [13:0] o_tx_index,
    output logic        o_tx_enable,
    output logic [8:0]  o_rx_count,
    output logic        o_rx_complete,
    output logic        o_waiting_ack
);
    import psar_pkg::*;

    localparam int unsigned FILL_W = $clog2(RX_SIZE + 1);

    t_cfg              r_cfg;
    t_state            r_state;
    logic [FILL_W-1:0] r_fill;

    logic              r_s1_valid;
    logic [1:0]        r_s1_req;
    logic [7:0]        r_s1_byte;
    logic [13:0]       r_s1_len;

    logic              r_out_valid;
    t_result           r_out_result;
    logic              r_out_tx_enable;
    logic [8:0]        r_out_rx_count;
    logic              r_out_rx_complete;
    logic              r_out_waiting;

    t_state            n_state;
    logic [FILL_W-1:0] n_fill;
    t_result           n_result;

    logic w_advance;
    logic w_in_accept;

    assign w_advance   = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    psar_step #(
        .RX_SIZE(RX_SIZE)
    ) u_step (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_fill         (r_fill),
        .i_req_type     (r_s1_req),
        .i_rx_byte      (r_s1_byte),
        .i_frame_length (r_s1_len),
        .o_state        (n_state),
        .o_fill         (n_fill),
        .o_result       (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.send_period    <= SEND_PERIOD_RST;
            r_cfg.ack_wait_ticks <= ACK_WAIT_RST;
            r_cfg.ack_type_code  <= ACK_CODE_RST;
            r_cfg.retry_limit    <= RETRY_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SEND_PERIOD: r_cfg.send_period    <= i_cfg_data;
                CFG_ACK_WAIT:    r_cfg.ack_wait_ticks <= i_cfg_data;
                CFG_ACK_CODE:    r_cfg.ack_type_code  <= i_cfg_data[BYTE_W-1:0];
                CFG_RETRY_LIMIT: r_cfg.retry_limit    <= i_cfg_data[RETRY_W-1:0];
            endcase
        end
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
        if (w_in_accept) begin
            r_s1_req  <= i_req_type;
            r_s1_byte <= i_rx_byte;
            r_s1_len  <= i_frame_length;
        end
    end

    // protocol state advances once per word passed to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_fill  <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance) begin
            r_out_result      <= n_result;
            r_out_tx_enable   <= n_state.tx_running;
            r_out_rx_count    <= 9'(n_fill);
            r_out_rx_complete <= n_state.rx_closed;
            r_out_waiting     <= n_state.awaiting_reply;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_res   = r_out_result.ev;
    assign o_tx_index    = r_out_result.tx_index;
    assign o_tx_enable   = r_out_tx_enable;
    assign o_rx_count    = r_out_rx_count;
    assign o_rx_complete = r_out_rx_complete;
    assign o_waiting_ack = r_out_waiting;

`ifndef NO_ASSERTIONS
    a_send_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res == EV_SEND) |-> o_waiting_ack)
        else $error("send reported without an open exchange");

    a_close_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == EV_ACK || o_event_res == EV_GIVEUP))
        |-> !o_waiting_ack)
        else $error("exchange still open after ack or give-up");

    a_running_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.tx_running |-> (r_state.tx_total != '0))
        else $error("transmitter running on an empty frame");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s1_valid))
        else $error("result appeared without a held input word");
`endif

endmodule
